// ===== rtl/core/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, register codes and constants of the SYNC timing block.
// ----------------------------------------------------------------------------
package cst_pkg;

   // Timer tick length in microseconds.
   localparam int unsigned TICK_US = 1000;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [7:0]  CNT_MIN  = 8'd1;
   localparam logic [7:0]  CNT_MAX  = 8'd240;

   // Division by TICK_US as a multiplication by a rounded-up reciprocal.
   // With the shift 32 + ceil(log2(TICK_US)) the quotient is exact for every
   // 32-bit dividend.
   localparam int unsigned TICK_LOG = $clog2(TICK_US);
   localparam int unsigned RECIP_SH = 32 + TICK_LOG;
   localparam logic [63:0] RECIP_W  =
      ((64'd1 << RECIP_SH) + 64'(TICK_US) - 64'd1) / 64'(TICK_US);
   localparam logic [32:0] RECIP    = RECIP_W[32:0];
   localparam int unsigned PROD_W   = 65 + TICK_LOG;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_SYNC_ID  = 3'd0,
      REG_GENERATE = 3'd1,
      REG_PERIOD   = 3'd2,
      REG_WINDOW   = 3'd3,
      REG_OVERFLOW = 3'd4
   } reg_index_type;

   // Result word contents.
   typedef struct packed {
      logic        window_closed;
      logic        sync_missing;
      logic        length_error;
      logic [7:0]  sync_value;
      logic        sync_seen;
      logic [7:0]  send_counter;
      logic        send_len;
      logic [10:0] send_id;
      logic        send_valid;
   } rsp_type;

   function automatic logic [31:0] div_tick(input logic [31:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP);
      return prod[RECIP_SH +: 32];
   endfunction

endpackage

// ===== rtl/core/canopen_sync_timer.sv =====
// ----------------------------------------------------------------------------
// canopen_sync_timer
// SYNC producer/consumer timing: period countdown, synchronous window and
// rolling SYNC counter, one result word for every input word.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | tuser: kind; tdata: frame_len, frame_counter
//  rsp_     | out       | tdata: send, sync, error, timeout and window flags
//  csr_     | in        | write enable, register index, 32-bit write data
//
// One word per cycle sustained while rsp_tready does not stall the result;
// an accepted input word passes the input register, then the result register.
// The division of period and window lengths by the tick is done with one
// shared reciprocal multiplier at configuration write time.
// Reset is synchronous and restores the configuration, the timing state and
// the valid flags; the data registers of both stages are not reset.
// A stalled result register holds the input stage, which then holds req_tready
// low once it is full as well.
// ----------------------------------------------------------------------------
module canopen_sync_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // kind
   input  logic [15:0] req_tdata,   // frame_len[3:0], frame_counter[11:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // send_valid[0], send_id[11:1], send_len[12], send_counter[20:13],
   // sync_seen[21], sync_value[29:22], length_error[30], sync_missing[31],
   // window_closed[32], zero pad
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cst_pkg::*;

   // Configuration.
   logic [10:0] sync_id_ff,    sync_id_in;
   logic        gen_ff,        gen_in;
   logic        period_nz_ff,  period_nz_in;
   logic [31:0] period_q_ff,   period_q_in;
   logic        window_nz_ff,  window_nz_in;
   logic [31:0] win_load_ff,   win_load_in;
   logic [7:0]  overflow_ff,   overflow_in;

   // Timing state.
   logic [31:0] ticks_ff,      ticks_in;
   logic [31:0] pcnt_ff,       pcnt_in;
   logic [31:0] wcnt_ff,       wcnt_in;
   logic [7:0]  next_ctr_ff,   next_ctr_in;

   // Input stage and result stage.
   logic        s1_valid_ff,   s1_valid_in;
   logic        s1_kind_ff;
   logic [3:0]  s1_len_ff;
   logic [7:0]  s1_ctr_ff;
   logic        rsp_valid_ff,  rsp_valid_in;
   rsp_type     rsp_ff,        rsp_in;

   logic        out_free;
   logic        advance;
   logic        req_fire;

   logic [31:0] wdata_q;
   logic [31:0] rl_q;
   logic        rl_period_nz;
   logic        rl_gen;
   logic [31:0] rl_t1;
   logic [31:0] rl_t2;

   logic        use_ctr;
   logic [3:0]  fr_len;
   logic [7:0]  fr_ctr;
   logic        fr_ok;
   logic        fr_lerr;
   logic [31:0] pdec;
   logic [8:0]  ctr_inc;
   reg_index_type csr_code;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   assign use_ctr    = overflow_ff > CNT_MIN;
   assign csr_code   = reg_index_type'(csr_index);

   // The one reciprocal multiplier serves every write.
   assign wdata_q    = div_tick(csr_wdata);

   // Period reload values, using the new register value where it is written.
   assign rl_q         = (csr_code == REG_PERIOD) ? wdata_q : period_q_ff;
   assign rl_period_nz = (csr_code == REG_PERIOD) ? (csr_wdata != 32'd0) : period_nz_ff;
   assign rl_gen       = (csr_code == REG_GENERATE) ? csr_wdata[0] : gen_ff;
   assign rl_t1        = (rl_q == 32'd0) ? 32'd1 : rl_q;
   assign rl_t2        = (rl_t1 == ALL_ONES) ? rl_t1 : rl_t1 + 32'd1;

   // Frame check: either the received frame or the one just produced.
   // Without a counter byte the accepted value is zero.
   always_comb begin
      if (s1_kind_ff) begin
         fr_len = s1_len_ff;
         fr_ctr = use_ctr ? s1_ctr_ff : 8'd0;
      end else begin
         fr_len = {3'd0, use_ctr};
         fr_ctr = use_ctr ? next_ctr_ff : 8'd0;
      end
      fr_ok   = 1'b0;
      fr_lerr = 1'b0;
      if (use_ctr) begin
         if (fr_len != 4'd1) begin
            fr_lerr = 1'b1;
         end else if (fr_ctr >= CNT_MIN && fr_ctr <= CNT_MAX) begin
            fr_ok = 1'b1;
         end
      end else begin
         if (fr_len != 4'd0) begin
            fr_lerr = 1'b1;
         end else begin
            fr_ok = 1'b1;
         end
      end
   end

   assign pdec    = pcnt_ff - 32'd1;
   assign ctr_inc = {1'b0, next_ctr_ff} + 9'd1;

   always_comb begin
      sync_id_in   = sync_id_ff;
      gen_in       = gen_ff;
      period_nz_in = period_nz_ff;
      period_q_in  = period_q_ff;
      window_nz_in = window_nz_ff;
      win_load_in  = win_load_ff;
      overflow_in  = overflow_ff;
      ticks_in     = ticks_ff;
      pcnt_in      = pcnt_ff;
      wcnt_in      = wcnt_ff;
      next_ctr_in  = next_ctr_ff;
      s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      rsp_in       = rsp_ff;

      if (advance) begin
         rsp_in = '0;
         if (s1_kind_ff) begin
            if (fr_ok) begin
               pcnt_in           = ticks_ff;
               wcnt_in           = win_load_ff;
               rsp_in.sync_seen  = 1'b1;
               rsp_in.sync_value = fr_ctr;
            end
            rsp_in.length_error = fr_lerr;
         end else begin
            if (wcnt_ff != 32'd0) begin
               wcnt_in = wcnt_ff - 32'd1;
            end
            if (ticks_ff != 32'd0 && pcnt_ff != 32'd0) begin
               pcnt_in = pdec;
               if (pdec == 32'd0) begin
                  if (gen_ff) begin
                     if (use_ctr) begin
                        next_ctr_in = (ctr_inc > {1'b0, overflow_ff}) ? CNT_MIN
                                                                     : ctr_inc[7:0];
                     end
                     rsp_in.send_valid   = 1'b1;
                     rsp_in.send_id      = sync_id_ff;
                     rsp_in.send_len     = use_ctr;
                     rsp_in.send_counter = fr_ctr;
                     // A produced counter outside the valid range is sent but
                     // not taken as a SYNC, so the countdown stays at zero.
                     if (fr_ok) begin
                        pcnt_in           = ticks_ff;
                        wcnt_in           = win_load_ff;
                        rsp_in.sync_seen  = 1'b1;
                        rsp_in.sync_value = fr_ctr;
                     end
                  end else begin
                     pcnt_in             = ticks_ff;
                     rsp_in.sync_missing = 1'b1;
                  end
               end
            end
         end
         rsp_in.window_closed = window_nz_ff && (wcnt_in == 32'd0);
      end

      if (csr_we) begin
         case (csr_code)
            REG_SYNC_ID:  sync_id_in  = csr_wdata[10:0];
            REG_GENERATE: gen_in      = csr_wdata[0];
            REG_PERIOD: begin
               period_nz_in = csr_wdata != 32'd0;
               period_q_in  = wdata_q;
            end
            REG_WINDOW: begin
               window_nz_in = csr_wdata != 32'd0;
               win_load_in  = (wdata_q == ALL_ONES) ? ALL_ONES : wdata_q + 32'd1;
            end
            REG_OVERFLOW: overflow_in = csr_wdata[7:0];
            default: ;
         endcase
         if (csr_code == REG_SYNC_ID || csr_code == REG_GENERATE ||
             csr_code == REG_PERIOD || csr_code == REG_OVERFLOW) begin
            if (csr_code != REG_PERIOD) begin
               next_ctr_in = CNT_MIN;
            end
            if (!rl_period_nz) begin
               ticks_in    = 32'd0;
               pcnt_in     = ALL_ONES;
               next_ctr_in = CNT_MIN;
            end else if (rl_gen) begin
               ticks_in = rl_t1;
               pcnt_in  = 32'd1;
            end else begin
               ticks_in = rl_t2;
               pcnt_in  = rl_t2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_id_ff   <= 11'd128;
         gen_ff       <= 1'b0;
         period_nz_ff <= 1'b0;
         period_q_ff  <= 32'd0;
         window_nz_ff <= 1'b0;
         win_load_ff  <= 32'd1;
         overflow_ff  <= 8'd0;
         ticks_ff     <= 32'd0;
         pcnt_ff      <= ALL_ONES;
         wcnt_ff      <= 32'd0;
         next_ctr_ff  <= CNT_MIN;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sync_id_ff   <= sync_id_in;
         gen_ff       <= gen_in;
         period_nz_ff <= period_nz_in;
         period_q_ff  <= period_q_in;
         window_nz_ff <= window_nz_in;
         win_load_ff  <= win_load_in;
         overflow_ff  <= overflow_in;
         ticks_ff     <= ticks_in;
         pcnt_ff      <= pcnt_in;
         wcnt_ff      <= wcnt_in;
         next_ctr_ff  <= next_ctr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser[0];
         s1_len_ff  <= req_tdata[3:0];
         s1_ctr_ff  <= req_tdata[11:4];
      end
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a full pipeline");

   a_send_or_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.send_valid && rsp_ff.sync_missing))
      else $error("produced SYNC and timeout in the same word");

   a_seen_or_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.sync_seen && rsp_ff.length_error))
      else $error("accepted SYNC flagged with a length error");

   a_value_needs_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.sync_seen |-> rsp_ff.sync_value == 8'd0)
      else $error("SYNC value without an accepted SYNC");

   a_counter_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_ctr_ff != 8'd0)
      else $error("rolling counter reached zero");
`endif

endmodule
